// File: rtl/ssd_pkg.sv
`timescale 1ns / 1ps
package ssd_pkg;

    localparam int COORD_BITS = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int DIST_W     = 33;
    localparam int ROOT_W     = DIST_W;
    localparam int SQ_W       = 2 * ROOT_W;
    localparam int SQ_REM_W   = ROOT_W + 2;
    localparam int QUO_W      = SQ_W;
    // setup stages, divide cells, root cells, output stage
    localparam int LANE_LAT   = 6 + QUO_W + ROOT_W + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t p0_x;
        coord_t p0_y;
        coord_t p1_x;
        coord_t p1_y;
        coord_t q0_x;
        coord_t q0_y;
        coord_t q1_x;
        coord_t q1_y;
    } seg_pair_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              crossing;
    } seg_dist_t;

endpackage

// File: rtl/ssd_div_cell.sv
`timescale 1ns / 1ps
// one restoring divide step; nq holds the remaining dividend bits, quotient shifts in below
module ssd_div_cell #(
    parameter int DW = 8,
    parameter int QB = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] d_in,
    input  logic [DW-1:0] rem_in,
    input  logic [QB-1:0] nq_in,
    output logic [DW-1:0] d_out,
    output logic [DW-1:0] rem_out,
    output logic [QB-1:0] nq_out
);

    logic [DW-1:0] d_reg;
    logic [DW-1:0] rem_reg;
    logic [QB-1:0] nq_reg;
    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;

    assign sh   = {rem_in, nq_in[QB-1]};
    assign diff = sh - {1'b0, d_in};
    assign ge   = (sh >= {1'b0, d_in});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg   <= d_in;
            rem_reg <= ge ? diff[DW-1:0] : sh[DW-1:0];
            nq_reg  <= {nq_in[QB-2:0], ge};
        end
    end

    assign d_out   = d_reg;
    assign rem_out = rem_reg;
    assign nq_out  = nq_reg;

endmodule

// File: rtl/ssd_sqrt_cell.sv
`timescale 1ns / 1ps
// one digit of the bit-by-bit integer square root
module ssd_sqrt_cell (
    input  logic                         clk,
    input  logic                         en,
    input  logic [ssd_pkg::SQ_W-1:0]     x_in,
    input  logic [ssd_pkg::SQ_REM_W-1:0] rem_in,
    input  logic [ssd_pkg::ROOT_W-1:0]   root_in,
    output logic [ssd_pkg::SQ_W-1:0]     x_out,
    output logic [ssd_pkg::SQ_REM_W-1:0] rem_out,
    output logic [ssd_pkg::ROOT_W-1:0]   root_out
);

    localparam int XW = ssd_pkg::SQ_W;
    localparam int RW = ssd_pkg::SQ_REM_W;
    localparam int TW = ssd_pkg::ROOT_W;

    logic [XW-1:0] x_reg;
    logic [RW-1:0] rem_reg;
    logic [TW-1:0] root_reg;
    logic [RW+1:0] sh;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;
    logic          ge;

    assign sh    = {rem_in, x_in[XW-1:XW-2]};
    assign trial = (RW + 2)'({root_in, 2'b01});
    assign diff  = sh - trial;
    assign ge    = (sh >= trial);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= {x_in[XW-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW-1:0] : sh[RW-1:0];
            root_reg <= {root_in[TW-2:0], ge};
        end
    end

    assign x_out    = x_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// File: rtl/ssd_pt_seg.sv
`timescale 1ns / 1ps
// point to segment distance
module ssd_pt_seg (
    input  logic                       clk,
    input  logic                       en,
    input  ssd_pkg::coord_t            px,
    input  ssd_pkg::coord_t            py,
    input  ssd_pkg::coord_t            ax,
    input  ssd_pkg::coord_t            ay,
    input  ssd_pkg::coord_t            bx,
    input  ssd_pkg::coord_t            by,
    output logic [ssd_pkg::DIST_W-1:0] gap
);

    localparam int W    = ssd_pkg::DIFF_W;
    localparam int PW   = 2 * W;
    localparam int SW   = PW + 1;
    localparam int AW   = SW;
    localparam int HL   = (AW + 1) / 2;
    localparam int HH   = AW - HL;
    localparam int QW   = ssd_pkg::QUO_W;
    localparam int NW0  = 2 * AW;
    localparam int NW   = (NW0 > QW + 1) ? NW0 : QW + 1;
    localparam int DW   = SW;
    localparam int HIW  = NW - QW;
    localparam int CW   = (HIW > DW) ? HIW : DW;
    localparam int TW   = ssd_pkg::ROOT_W;
    localparam int XW   = ssd_pkg::SQ_W;
    localparam int RW   = ssd_pkg::SQ_REM_W;
    localparam int SD_N = QW + TW;

    logic signed [W-1:0]  dx_reg, dy_reg, ex_reg, ey_reg, fx_reg, fy_reg;
    logic signed [PW-1:0] dxx_reg, dyy_reg, edx_reg, edy_reg, exdy_reg, eydx_reg;
    logic signed [PW-1:0] exx_reg, eyy_reg, fxx_reg, fyy_reg;
    logic signed [SW-1:0] len2_reg, dot_reg, cr_reg, he_reg, hf_reg;

    logic                 use_e, use_f, use_c;
    logic [AW-1:0]        crabs;
    logic [HL-1:0]        cr_lo;
    logic [HH-1:0]        cr_hi;
    logic [2*HL-1:0]      ll_reg;
    logic [HL+HH-1:0]     lh_reg;
    logic [2*HH-1:0]      hh_reg;
    logic [SW-1:0]        hsel_reg;
    logic [DW-1:0]        len2u_reg;
    logic                 usec_reg;

    logic [NW-1:0]        n_reg;
    logic [DW-1:0]        d_reg;

    logic [CW-1:0]        hi_ext;
    logic [DW-1:0]        rem6_reg;
    logic [QW-1:0]        nq6_reg;
    logic [DW-1:0]        d6_reg;
    logic                 sat6_reg;
    logic                 sd_reg [SD_N];

    logic [DW-1:0]        c_d   [QW+1];
    logic [DW-1:0]        c_rem [QW+1];
    logic [QW-1:0]        c_nq  [QW+1];
    logic [XW-1:0]        s_x    [TW+1];
    logic [RW-1:0]        s_rem  [TW+1];
    logic [TW-1:0]        s_root [TW+1];

    logic [ssd_pkg::DIST_W-1:0] dist_reg;

    assign use_e = (len2_reg == 0) || (dot_reg <= 0);
    assign use_f = !use_e && (dot_reg >= len2_reg);
    assign use_c = !use_e && !use_f;
    assign crabs = cr_reg[SW-1] ? $unsigned(-cr_reg) : $unsigned(cr_reg);
    assign cr_lo = crabs[HL-1:0];
    assign cr_hi = crabs[AW-1:HL];
    assign hi_ext = CW'(n_reg[NW-1:QW]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= W'(bx) - W'(ax);
            dy_reg <= W'(by) - W'(ay);
            ex_reg <= W'(px) - W'(ax);
            ey_reg <= W'(py) - W'(ay);
            fx_reg <= W'(px) - W'(bx);
            fy_reg <= W'(py) - W'(by);

            dxx_reg  <= dx_reg * dx_reg;
            dyy_reg  <= dy_reg * dy_reg;
            edx_reg  <= ex_reg * dx_reg;
            edy_reg  <= ey_reg * dy_reg;
            exdy_reg <= ex_reg * dy_reg;
            eydx_reg <= ey_reg * dx_reg;
            exx_reg  <= ex_reg * ex_reg;
            eyy_reg  <= ey_reg * ey_reg;
            fxx_reg  <= fx_reg * fx_reg;
            fyy_reg  <= fy_reg * fy_reg;

            len2_reg <= SW'(dxx_reg) + SW'(dyy_reg);
            dot_reg  <= SW'(edx_reg) + SW'(edy_reg);
            cr_reg   <= SW'(exdy_reg) - SW'(eydx_reg);
            he_reg   <= SW'(exx_reg) + SW'(eyy_reg);
            hf_reg   <= SW'(fxx_reg) + SW'(fyy_reg);

            ll_reg    <= cr_lo * cr_lo;
            lh_reg    <= cr_lo * cr_hi;
            hh_reg    <= cr_hi * cr_hi;
            hsel_reg  <= use_e ? $unsigned(he_reg) : $unsigned(hf_reg);
            len2u_reg <= $unsigned(len2_reg);
            usec_reg  <= use_c;

            n_reg <= usec_reg ? (NW'(hh_reg) << (2 * HL)) + (NW'(lh_reg) << (HL + 1))
                                + NW'(ll_reg)
                              : NW'(hsel_reg);
            d_reg <= usec_reg ? len2u_reg : DW'(1);

            // quotient beyond the root range saturates the distance
            sat6_reg <= (hi_ext >= CW'(d_reg));
            rem6_reg <= hi_ext[DW-1:0];
            nq6_reg  <= n_reg[QW-1:0];
            d6_reg   <= d_reg;

            sd_reg[0] <= sat6_reg;
            for (int k = 1; k < SD_N; k++)
            begin
                sd_reg[k] <= sd_reg[k-1];
            end

            dist_reg <= sd_reg[SD_N-1] ? {ssd_pkg::DIST_W{1'b1}}
                                       : ssd_pkg::DIST_W'(s_root[TW]);
        end
    end

    assign c_d[0]   = d6_reg;
    assign c_rem[0] = rem6_reg;
    assign c_nq[0]  = nq6_reg;

    for (genvar g = 0; g < QW; g++)
    begin : g_div
        ssd_div_cell #(
            .DW (DW),
            .QB (QW)
        ) u_cell (
            .clk     (clk),
            .en      (en),
            .d_in    (c_d[g]),
            .rem_in  (c_rem[g]),
            .nq_in   (c_nq[g]),
            .d_out   (c_d[g+1]),
            .rem_out (c_rem[g+1]),
            .nq_out  (c_nq[g+1])
        );
    end

    assign s_x[0]    = XW'(c_nq[QW]);
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;

    for (genvar g = 0; g < TW; g++)
    begin : g_sqrt
        ssd_sqrt_cell u_cell (
            .clk      (clk),
            .en       (en),
            .x_in     (s_x[g]),
            .rem_in   (s_rem[g]),
            .root_in  (s_root[g]),
            .x_out    (s_x[g+1]),
            .rem_out  (s_rem[g+1]),
            .root_out (s_root[g+1])
        );
    end

    assign gap = dist_reg;

endmodule

// File: rtl/segment_segment_distance.sv
`timescale 1ns / 1ps
// Distance between two 2D segments, signed Q16.16 in, unsigned Q17.16 out.
// pair channel: one beat carries both segments (valid/ready).
// result channel: one beat carries distance and the crossing flag.
// cfg channel: writes the parallel threshold; always ready, reset value 0.
// Throughput: one pair per clock while pair_ready is high. The pipeline
// length is set by the 66-cell divide chain and the
// 33-cell square root chain in each of the four point-to-segment lanes.
// The crossing test runs alongside through its own 32-cell divide chains.
// A stalled result beat holds in the output register; the pipeline keeps
// accepting pairs until a finished beat reaches the stage behind it, then
// pair_ready drops until the receiver takes the result.
// Reset clears all valid flags and the threshold; no beat is in flight.
module segment_segment_distance (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pair_valid,
    output logic               pair_ready,
    input  ssd_pkg::seg_pair_t pair,
    output logic               result_valid,
    input  logic               result_ready,
    output ssd_pkg::seg_dist_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_threshold
);

    localparam int C      = ssd_pkg::COORD_BITS;
    localparam int W      = ssd_pkg::DIFF_W;
    localparam int PW     = 2 * W;
    localparam int SW     = PW + 1;
    localparam int MW     = W + C;
    localparam int KW     = MW + 1;
    localparam int BL     = KW / 2;
    localparam int BH     = KW - BL;
    localparam int NXW    = W + KW + 1;
    localparam int HXW    = NXW - C;
    localparam int CXW    = (HXW > SW) ? HXW : SW;
    localparam int DW     = ssd_pkg::DIST_W;
    localparam int LAST   = ssd_pkg::LANE_LAT + 2;
    localparam int SPAN_N = C + 6;
    localparam int NP_N   = C + 2;
    localparam int FL_N   = C;
    localparam int CX_N   = LAST - (7 + C);

    typedef struct packed {
        ssd_pkg::coord_t lox;
        ssd_pkg::coord_t hix;
        ssd_pkg::coord_t loy;
        ssd_pkg::coord_t hiy;
    } span_t;

    typedef struct packed {
        logic satx;
        logic negx;
        logic saty;
        logic negy;
    } dflag_t;

    logic               en;
    logic               out_load;
    logic               v_reg [LAST+1];
    ssd_pkg::seg_pair_t pair_reg;
    logic [31:0]        thr_reg;
    ssd_pkg::seg_dist_t result_reg;
    logic               result_valid_reg;

    // crossing path
    logic signed [W-1:0]  dpx1_reg, dpy1_reg, dqx1_reg, dqy1_reg;
    ssd_pkg::coord_t      p0x1_reg, p0y1_reg, q0x1_reg, q0y1_reg;
    span_t                span1;
    span_t                sp_reg [SPAN_N];
    logic signed [PW-1:0] m1_reg, m2_reg;
    logic signed [MW-1:0] m3_reg, m4_reg, m5_reg, m6_reg;
    logic signed [W-1:0]  dpx2_reg, dpy2_reg, dqx2_reg, dqy2_reg;
    logic signed [SW-1:0] pq_reg;
    logic signed [KW-1:0] pc_reg, qc_reg;
    logic signed [W-1:0]  dpx3_reg, dpy3_reg, dqx3_reg, dqy3_reg;
    logic [SW-1:0]        apq;
    logic signed [BH-1:0] pch, qch;
    logic [BL-1:0]        pcl, qcl;
    logic signed [W+BH-1:0] xph_reg, xqh_reg, yph_reg, yqh_reg;
    logic signed [W+BL:0]   xpl_reg, xql_reg, ypl_reg, yql_reg;
    logic [SW-1:0]        apq4_reg, apq5_reg;
    logic                 pqneg4_reg, pqneg5_reg;
    logic                 npar4_reg;
    logic                 np_reg [NP_N];
    logic signed [NXW-1:0] nx_reg, ny_reg;
    logic [NXW-1:0]       anx, any_;
    logic [CXW-1:0]       hx_e, hy_e;
    logic [SW-1:0]        xr6_reg, yr6_reg, d6_reg;
    logic [C-1:0]         xq6_reg, yq6_reg;
    dflag_t               fl6_reg;
    dflag_t               fl_reg [FL_N];
    logic [SW-1:0]        xd [C+1];
    logic [SW-1:0]        xr [C+1];
    logic [C-1:0]         xq [C+1];
    logic [SW-1:0]        yd [C+1];
    logic [SW-1:0]        yr [C+1];
    logic [C-1:0]         yq [C+1];
    logic signed [C:0]    gx, gy;
    span_t                spe;
    dflag_t               fle;
    logic                 inx, iny;
    logic                 cx_reg [CX_N+1];

    // distance path
    logic [DW-1:0]        ld [4];
    logic [DW-1:0]        m01_reg, m23_reg, mall_reg;

    assign out_load   = !result_valid_reg || result_ready;
    assign en         = !v_reg[LAST] || out_load;
    assign pair_ready = en;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg          <= '0;
            result_valid_reg <= 1'b0;
            for (int k = 0; k <= LAST; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_threshold;
            end
            if (out_load)
            begin
                result_valid_reg <= v_reg[LAST];
            end
            if (en)
            begin
                v_reg[0] <= pair_valid;
                for (int k = 1; k <= LAST; k++)
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        span1.lox = ((pair_reg.p0_x < pair_reg.p1_x) ? pair_reg.p0_x : pair_reg.p1_x);
        if (((pair_reg.q0_x < pair_reg.q1_x) ? pair_reg.q0_x : pair_reg.q1_x) > span1.lox)
        begin
            span1.lox = (pair_reg.q0_x < pair_reg.q1_x) ? pair_reg.q0_x : pair_reg.q1_x;
        end
        span1.hix = ((pair_reg.p0_x < pair_reg.p1_x) ? pair_reg.p1_x : pair_reg.p0_x);
        if (((pair_reg.q0_x < pair_reg.q1_x) ? pair_reg.q1_x : pair_reg.q0_x) < span1.hix)
        begin
            span1.hix = (pair_reg.q0_x < pair_reg.q1_x) ? pair_reg.q1_x : pair_reg.q0_x;
        end
        span1.loy = ((pair_reg.p0_y < pair_reg.p1_y) ? pair_reg.p0_y : pair_reg.p1_y);
        if (((pair_reg.q0_y < pair_reg.q1_y) ? pair_reg.q0_y : pair_reg.q1_y) > span1.loy)
        begin
            span1.loy = (pair_reg.q0_y < pair_reg.q1_y) ? pair_reg.q0_y : pair_reg.q1_y;
        end
        span1.hiy = ((pair_reg.p0_y < pair_reg.p1_y) ? pair_reg.p1_y : pair_reg.p0_y);
        if (((pair_reg.q0_y < pair_reg.q1_y) ? pair_reg.q1_y : pair_reg.q0_y) < span1.hiy)
        begin
            span1.hiy = (pair_reg.q0_y < pair_reg.q1_y) ? pair_reg.q1_y : pair_reg.q0_y;
        end
    end

    assign apq  = pq_reg[SW-1] ? $unsigned(-pq_reg) : $unsigned(pq_reg);
    assign pch  = pc_reg[KW-1:BL];
    assign pcl  = pc_reg[BL-1:0];
    assign qch  = qc_reg[KW-1:BL];
    assign qcl  = qc_reg[BL-1:0];
    assign anx  = nx_reg[NXW-1] ? $unsigned(-nx_reg) : $unsigned(nx_reg);
    assign any_ = ny_reg[NXW-1] ? $unsigned(-ny_reg) : $unsigned(ny_reg);
    assign hx_e = CXW'(anx[NXW-1:C]);
    assign hy_e = CXW'(any_[NXW-1:C]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair_reg <= pair;

            dpx1_reg <= W'(pair_reg.p1_x) - W'(pair_reg.p0_x);
            dpy1_reg <= W'(pair_reg.p1_y) - W'(pair_reg.p0_y);
            dqx1_reg <= W'(pair_reg.q1_x) - W'(pair_reg.q0_x);
            dqy1_reg <= W'(pair_reg.q1_y) - W'(pair_reg.q0_y);
            p0x1_reg <= pair_reg.p0_x;
            p0y1_reg <= pair_reg.p0_y;
            q0x1_reg <= pair_reg.q0_x;
            q0y1_reg <= pair_reg.q0_y;

            sp_reg[0] <= span1;
            for (int k = 1; k < SPAN_N; k++)
            begin
                sp_reg[k] <= sp_reg[k-1];
            end

            m1_reg   <= dpx1_reg * dqy1_reg;
            m2_reg   <= dpy1_reg * dqx1_reg;
            m3_reg   <= dpx1_reg * p0y1_reg;
            m4_reg   <= dpy1_reg * p0x1_reg;
            m5_reg   <= dqx1_reg * q0y1_reg;
            m6_reg   <= dqy1_reg * q0x1_reg;
            dpx2_reg <= dpx1_reg;
            dpy2_reg <= dpy1_reg;
            dqx2_reg <= dqx1_reg;
            dqy2_reg <= dqy1_reg;

            pq_reg   <= SW'(m1_reg) - SW'(m2_reg);
            pc_reg   <= KW'(m3_reg) - KW'(m4_reg);
            qc_reg   <= KW'(m5_reg) - KW'(m6_reg);
            dpx3_reg <= dpx2_reg;
            dpy3_reg <= dpy2_reg;
            dqx3_reg <= dqx2_reg;
            dqy3_reg <= dqy2_reg;

            // numerators split into half-width partial products
            xph_reg    <= dqx3_reg * pch;
            xpl_reg    <= dqx3_reg * $signed({1'b0, pcl});
            xqh_reg    <= dpx3_reg * qch;
            xql_reg    <= dpx3_reg * $signed({1'b0, qcl});
            yph_reg    <= dqy3_reg * pch;
            ypl_reg    <= dqy3_reg * $signed({1'b0, pcl});
            yqh_reg    <= dpy3_reg * qch;
            yql_reg    <= dpy3_reg * $signed({1'b0, qcl});
            apq4_reg   <= apq;
            pqneg4_reg <= pq_reg[SW-1];
            npar4_reg  <= (apq > SW'(thr_reg));

            nx_reg <= (NXW'(xph_reg) << BL) + NXW'(xpl_reg)
                      - (NXW'(xqh_reg) << BL) - NXW'(xql_reg);
            ny_reg <= (NXW'(yph_reg) << BL) + NXW'(ypl_reg)
                      - (NXW'(yqh_reg) << BL) - NXW'(yql_reg);
            apq5_reg   <= apq4_reg;
            pqneg5_reg <= pqneg4_reg;

            np_reg[0] <= npar4_reg;
            for (int k = 1; k < NP_N; k++)
            begin
                np_reg[k] <= np_reg[k-1];
            end

            xr6_reg      <= hx_e[SW-1:0];
            yr6_reg      <= hy_e[SW-1:0];
            xq6_reg      <= anx[C-1:0];
            yq6_reg      <= any_[C-1:0];
            d6_reg       <= apq5_reg;
            fl6_reg.satx <= (hx_e >= CXW'(apq5_reg));
            fl6_reg.saty <= (hy_e >= CXW'(apq5_reg));
            fl6_reg.negx <= nx_reg[NXW-1] ^ pqneg5_reg;
            fl6_reg.negy <= ny_reg[NXW-1] ^ pqneg5_reg;

            fl_reg[0] <= fl6_reg;
            for (int k = 1; k < FL_N; k++)
            begin
                fl_reg[k] <= fl_reg[k-1];
            end

            cx_reg[0] <= np_reg[NP_N-1] && inx && iny;
            for (int k = 1; k <= CX_N; k++)
            begin
                cx_reg[k] <= cx_reg[k-1];
            end

            m01_reg  <= (ld[1] < ld[0]) ? ld[1] : ld[0];
            m23_reg  <= (ld[3] < ld[2]) ? ld[3] : ld[2];
            mall_reg <= (m23_reg < m01_reg) ? m23_reg : m01_reg;
        end
        if (out_load)
        begin
            result_reg.crossing <= cx_reg[CX_N];
            result_reg.distance <= cx_reg[CX_N] ? '0 : mall_reg;
        end
    end

    assign xd[0] = d6_reg;
    assign xr[0] = xr6_reg;
    assign xq[0] = xq6_reg;
    assign yd[0] = d6_reg;
    assign yr[0] = yr6_reg;
    assign yq[0] = yq6_reg;

    for (genvar g = 0; g < C; g++)
    begin : g_xdiv
        ssd_div_cell #(
            .DW (SW),
            .QB (C)
        ) u_x (
            .clk     (clk),
            .en      (en),
            .d_in    (xd[g]),
            .rem_in  (xr[g]),
            .nq_in   (xq[g]),
            .d_out   (xd[g+1]),
            .rem_out (xr[g+1]),
            .nq_out  (xq[g+1])
        );
        ssd_div_cell #(
            .DW (SW),
            .QB (C)
        ) u_y (
            .clk     (clk),
            .en      (en),
            .d_in    (yd[g]),
            .rem_in  (yr[g]),
            .nq_in   (yq[g]),
            .d_out   (yd[g+1]),
            .rem_out (yr[g+1]),
            .nq_out  (yq[g+1])
        );
    end

    assign spe = sp_reg[SPAN_N-1];
    assign fle = fl_reg[FL_N-1];
    assign gx  = fle.negx ? -$signed({1'b0, xq[C]}) : $signed({1'b0, xq[C]});
    assign gy  = fle.negy ? -$signed({1'b0, yq[C]}) : $signed({1'b0, yq[C]});
    assign inx = !fle.satx && (gx >= (C + 1)'(spe.lox)) && (gx <= (C + 1)'(spe.hix));
    assign iny = !fle.saty && (gy >= (C + 1)'(spe.loy)) && (gy <= (C + 1)'(spe.hiy));

    ssd_pt_seg u_lane0 (
        .clk (clk),
        .en  (en),
        .px  (pair_reg.p0_x),
        .py  (pair_reg.p0_y),
        .ax  (pair_reg.q0_x),
        .ay  (pair_reg.q0_y),
        .bx  (pair_reg.q1_x),
        .by  (pair_reg.q1_y),
        .gap (ld[0])
    );

    ssd_pt_seg u_lane1 (
        .clk (clk),
        .en  (en),
        .px  (pair_reg.p1_x),
        .py  (pair_reg.p1_y),
        .ax  (pair_reg.q0_x),
        .ay  (pair_reg.q0_y),
        .bx  (pair_reg.q1_x),
        .by  (pair_reg.q1_y),
        .gap (ld[1])
    );

    ssd_pt_seg u_lane2 (
        .clk (clk),
        .en  (en),
        .px  (pair_reg.q0_x),
        .py  (pair_reg.q0_y),
        .ax  (pair_reg.p0_x),
        .ay  (pair_reg.p0_y),
        .bx  (pair_reg.p1_x),
        .by  (pair_reg.p1_y),
        .gap (ld[2])
    );

    ssd_pt_seg u_lane3 (
        .clk (clk),
        .en  (en),
        .px  (pair_reg.q1_x),
        .py  (pair_reg.q1_y),
        .ax  (pair_reg.p0_x),
        .ay  (pair_reg.p0_y),
        .bx  (pair_reg.p1_x),
        .by  (pair_reg.p1_y),
        .gap (ld[3])
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_cross_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.crossing |-> result.distance == '0)
        else $error("crossing beat with nonzero distance");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pair_ready |-> result_valid && !result_ready)
        else $error("pair_ready low without output stall");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(v_reg[LAST]))
        else $error("result beat without pipeline beat");

endmodule
